/* rtl/afrc_pkg.sv */
// ----------------------------------------------------------------------------
// afrc_pkg
// shared types and constants for the rate corrected audio fifo
// ----------------------------------------------------------------------------
package afrc_pkg;

    // storage words, at most DEPTH-1 of them in use
    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH);
    localparam int WORD_W  = 32;
    localparam int SAMP_W  = 16;
    localparam int FILL_W  = 12;
    localparam int ADD_W   = 12;
    localparam int THR_W   = 13;
    localparam int ACC_W   = 13;
    localparam int SUM_W   = ACC_W + 1;

    localparam logic [ADD_W-1:0] ADDEND_RESET    = ADD_W'(785);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1024);
    localparam logic [ACC_W-1:0] ACC_MAX         = '1;

    // apb register indexes
    localparam logic REG_ADDEND    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH      = 2'd0,
        OP_FRAME_END = 2'd1,
        OP_POP       = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef struct packed {
        logic [ADD_W-1:0] addend;
        logic [THR_W-1:0] threshold;
    } cfg_t;

    // per item status handed from control to the output stage
    typedef struct packed {
        logic              pop_ok;
        logic              underrun;
        logic              dropped;
        logic              silence;
        logic [FILL_W-1:0] fill;
    } res_t;

endpackage

/* rtl/afrc_ram.sv */
// ----------------------------------------------------------------------------
// afrc_ram
// sample word store, one write and one registered read port
// ----------------------------------------------------------------------------
module afrc_ram
(
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [afrc_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [afrc_pkg::WORD_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [afrc_pkg::ADDR_W-1:0]    rd_addr,
    output logic [afrc_pkg::WORD_W-1:0]    rd_data
);
    import afrc_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/afrc_cfg.sv */
// ----------------------------------------------------------------------------
// afrc_cfg
// apb register file for the rate addend and threshold
// ----------------------------------------------------------------------------
module afrc_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output afrc_pkg::cfg_t    cfg
);
    import afrc_pkg::*;

    logic [ADD_W-1:0] addend_reg;
    logic [THR_W-1:0] threshold_reg;
    logic             wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addend_reg    <= ADDEND_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (wr_stb)
        begin
            unique case (paddr[2])
                REG_ADDEND:    addend_reg    <= pwdata[ADD_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ADDEND:    prdata = 32'(addend_reg);
            REG_THRESHOLD: prdata = 32'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.addend    = addend_reg;
    assign cfg.threshold = threshold_reg;

endmodule

/* rtl/afrc_ctrl.sv */
// ----------------------------------------------------------------------------
// afrc_ctrl
// ring pointers, fill count and rate accumulator; drives the store ports
// ----------------------------------------------------------------------------
module afrc_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  afrc_pkg::op_t                  op,
    input  logic [afrc_pkg::SAMP_W-1:0]    left_sample,
    input  logic [afrc_pkg::SAMP_W-1:0]    right_sample,
    input  afrc_pkg::cfg_t                 cfg,
    output logic                           wr_en,
    output logic [afrc_pkg::ADDR_W-1:0]    wr_addr,
    output logic [afrc_pkg::WORD_W-1:0]    wr_data,
    output logic                           rd_en,
    output logic [afrc_pkg::ADDR_W-1:0]    rd_addr,
    output afrc_pkg::res_t                 res
);
    import afrc_pkg::*;

    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  sum;
    logic              full;
    logic              empty;
    logic              put;

    assign full  = count_reg >= CNT_W'(DEPTH - 1);
    assign empty = count_reg == '0;

    always_comb
    begin
        put      = 1'b0;
        rd_en    = 1'b0;
        wr_data  = '0;
        acc_next = acc_reg;
        sum      = SUM_W'(acc_reg) + SUM_W'(cfg.addend);
        res      = '0;

        unique case (op)
            OP_PUSH:
            begin
                wr_data = {left_sample, right_sample};
                if (full)
                    res.dropped = 1'b1;
                else
                    put = 1'b1;
            end
            OP_FRAME_END:
            begin
                // silence word due once the accumulator reaches the threshold
                if (sum >= SUM_W'(cfg.threshold))
                begin
                    sum = sum - SUM_W'(cfg.threshold);
                    if (full)
                        res.dropped = 1'b1;
                    else
                    begin
                        put         = 1'b1;
                        res.silence = 1'b1;
                    end
                end
                if (sum > SUM_W'(ACC_MAX))
                    acc_next = ACC_MAX;
                else
                    acc_next = sum[ACC_W-1:0];
            end
            OP_POP:
            begin
                if (empty)
                    res.underrun = 1'b1;
                else
                begin
                    rd_en      = accept;
                    res.pop_ok = 1'b1;
                end
            end
            OP_NOP: ;
            default: ;
        endcase

        wr_en = put && accept;

        wr_idx_next = (wr_idx_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_idx_reg + ADDR_W'(1);
        rd_idx_next = (rd_idx_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_idx_reg + ADDR_W'(1);

        priority if (put)
            count_next = count_reg + CNT_W'(1);
        else if (res.pop_ok)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;

        res.fill = FILL_W'(count_next);
    end

    assign wr_addr = wr_idx_reg;
    assign rd_addr = rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            acc_reg    <= '0;
        end
        else if (accept)
        begin
            if (put)
                wr_idx_reg <= wr_idx_next;
            if (res.pop_ok)
                rd_idx_reg <= rd_idx_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

/* rtl/audio_fifo_rate_corrected_core.sv */
// ----------------------------------------------------------------------------
// audio_fifo_rate_corrected_core
// stereo sample fifo with silence padding driven by a fractional accumulator
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       tuser: operation, tdata: samples
//  m_*       out   m_tvalid / m_tready       tdata: word, flags, fill level
//  apb       in    psel, penable, pready     rate_addend @0, rate_threshold @4
//
//  one item per clock sustained while the output is not stalled; a result
//  passes the read stage, set by the registered read port, then the output register
//  asynchronous active-low reset clears pointers, count and accumulator;
//  the store itself is not cleared and needs no clearing pass
//  a stalled output holds its item while one more item waits in the read
//  stage; input stalls only when both are full
// ----------------------------------------------------------------------------
module audio_fifo_rate_corrected_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // left_sample[15:0], right_sample[31:16]
    input  logic [1:0]  s_tuser,    // operation[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // out_word[31:0], underrun[32], dropped[33],
                                    // silence_inserted[34], fill_level[46:35], zero[47]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import afrc_pkg::*;

    cfg_t              cfg;
    res_t              res;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;

    // read stage: status waits here while the store read completes
    logic              p_valid_reg;
    res_t              p_res_reg;
    logic              p_advance;

    // output register
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    res_t              out_res_reg;

    assign p_advance = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !p_valid_reg || p_advance;
    assign accept    = s_tvalid && s_tready;

    afrc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afrc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op_t'(s_tuser)),
        .left_sample  (s_tdata[SAMP_W-1:0]),
        .right_sample (s_tdata[2*SAMP_W-1:SAMP_W]),
        .cfg          (cfg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .res          (res)
    );

    // a pop only reads entries written by earlier items, so no forwarding
    afrc_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                p_valid_reg <= 1'b1;
            else if (p_advance)
                p_valid_reg <= 1'b0;

            if (p_advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            p_res_reg <= res;
        if (p_advance)
        begin
            out_res_reg  <= p_res_reg;
            // read data stays put until the next accepted pop
            out_word_reg <= p_res_reg.pop_ok ? rd_data : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.fill, out_res_reg.silence, out_res_reg.dropped,
                       out_res_reg.underrun, out_word_reg};

    // an underrun always delivers silence
    a_underrun_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == '0)
        else $error("underrun with nonzero word");

    // a drop only happens at full capacity
    a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[46:35] == FILL_W'(DEPTH - 1))
        else $error("drop below full");

    // a silence word is either written or dropped, never both
    a_sil_drop : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("silence both inserted and dropped");

    // an item is only accepted over a full read stage that moves on in the same cycle
    a_accept_room : assert property (@(posedge clk) disable iff (!rst_n)
        accept && p_valid_reg |-> p_advance)
        else $error("item accepted over a blocked read stage");

endmodule

/* sim/afrc_reply_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afrc_reply_checker
// snoops the apb port and both streams of the rate corrected audio fifo,
// keeps its own copy of the fifo and accumulator, and compares every result
// item with the oldest predicted one
// ----------------------------------------------------------------------------
module afrc_reply_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // left_sample[15:0], right_sample[31:16]
    input  logic [1:0]  s_tuser,    // operation[1:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,    // out_word[31:0], underrun[32], dropped[33],
                                    // silence_inserted[34], fill_level[46:35], zero[47]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,

    output int          mismatch_total,
    output int          replies_due
);
    import afrc_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              underrun;
        logic              dropped;
        logic              silence;
        logic [FILL_W-1:0] fill;
        logic              pad;
    } fifo_reply_t;

    logic [WORD_W-1:0] word_copy [DEPTH];
    int                wr_pos;
    int                rd_pos;
    int                held;
    logic [ACC_W-1:0]  acc_level;
    logic [ADD_W-1:0]  addend_reg;
    logic [THR_W-1:0]  threshold_reg;
    fifo_reply_t       fifo_replies [$];
    fifo_reply_t       seen;
    fifo_reply_t       want;
    int                errors;

    function automatic int wrap_next(input int pos);
        return (pos == DEPTH - 1) ? 0 : pos + 1;
    endfunction

    // stores a word if a slot is free, returns whether it was stored
    function automatic logic store_word(input logic [WORD_W-1:0] w);
        if (held >= DEPTH - 1)
            return 1'b0;
        word_copy[wr_pos] = w;
        wr_pos = wrap_next(wr_pos);
        held++;
        return 1'b1;
    endfunction

    task automatic apply_fifo_item(input op_t op, input logic [SAMP_W-1:0] left,
                                   input logic [SAMP_W-1:0] right);
        fifo_reply_t      r;
        logic [SUM_W-1:0] sum;
        r = '0;
        case (op)
            OP_PUSH:
            begin
                if (!store_word({left, right}))
                    r.dropped = 1'b1;
            end
            OP_FRAME_END:
            begin
                sum = SUM_W'(acc_level) + SUM_W'(addend_reg);
                if (sum >= SUM_W'(threshold_reg))
                begin
                    sum = sum - SUM_W'(threshold_reg);
                    if (store_word('0))
                        r.silence = 1'b1;
                    else
                        r.dropped = 1'b1;
                end
                if (sum > SUM_W'(ACC_MAX))
                    sum = SUM_W'(ACC_MAX);
                acc_level = sum[ACC_W-1:0];
            end
            OP_POP:
            begin
                if (held == 0)
                    r.underrun = 1'b1;
                else
                begin
                    r.word = word_copy[rd_pos];
                    rd_pos = wrap_next(rd_pos);
                    held--;
                end
            end
            default:
            begin
            end
        endcase
        r.fill = FILL_W'(held);
        fifo_replies.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos         = 0;
            rd_pos         = 0;
            held           = 0;
            acc_level      = '0;
            addend_reg     = ADDEND_RESET;
            threshold_reg  = THRESHOLD_RESET;
            errors         = 0;
            fifo_replies.delete();
            mismatch_total <= 0;
            replies_due    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ADDEND)
                    addend_reg = pwdata[ADD_W-1:0];
                else
                    threshold_reg = pwdata[THR_W-1:0];
            end

            if (m_tvalid && m_tready)
            begin
                seen.word     = m_tdata[31:0];
                seen.underrun = m_tdata[32];
                seen.dropped  = m_tdata[33];
                seen.silence  = m_tdata[34];
                seen.fill     = m_tdata[46:35];
                seen.pad      = m_tdata[47];
                if (fifo_replies.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result item: word %h un %b dr %b si %b fill %0d",
                                 seen.word, seen.underrun, seen.dropped, seen.silence,
                                 seen.fill);
                end
                else
                begin
                    want = fifo_replies.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected word %h un %b dr %b si %b fill %0d",
                                      " pad %b, got word %h un %b dr %b si %b fill %0d pad %b"},
                                     want.word, want.underrun, want.dropped, want.silence,
                                     want.fill, want.pad, seen.word, seen.underrun,
                                     seen.dropped, seen.silence, seen.fill, seen.pad);
                    end
                end
            end

            if (s_tvalid && s_tready)
                apply_fifo_item(op_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]);

            mismatch_total <= errors;
            replies_due    <= fifo_replies.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the rate corrected audio fifo: directed corner items, rate
// settings from the extremes, a push-heavy burst and a pop-heavy drain,
// with random idling on both streams; the checker beside the block judges
// ----------------------------------------------------------------------------
module tb;
    import afrc_pkg::*;

    // generous bound, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;

    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;    // left_sample[15:0], right_sample[31:16]
    logic [1:0]  s_tuser  = OP_NOP; // operation[1:0]
    wire         s_tready;

    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;          // out_word[31:0], underrun[32], dropped[33],
                                   // silence_inserted[34], fill_level[46:35], zero[47]

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;

    int          mismatch_total;
    int          replies_due;
    int          cycle_count = 0;
    int          hold_left   = 0;
    logic        calm        = 1'b0;   // no idling once set

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    audio_fifo_rate_corrected_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    afrc_reply_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_total (mismatch_total),
        .replies_due    (replies_due)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure: stalls of random length in random bursts
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(0, 3);
        end
        else
            m_tready <= 1'b1;
    end

    // sample value biased toward the extremes of a signed 16-bit field
    function automatic logic [SAMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    // weighted operation pick in percent, the remainder becomes a no-op
    function automatic op_t pick_op(input int push_w, input int frame_w, input int pop_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_w)
            return OP_PUSH;
        if (r < push_w + frame_w)
            return OP_FRAME_END;
        if (r < push_w + frame_w + pop_w)
            return OP_POP;
        return OP_NOP;
    endfunction

    // present one item and hold it until accepted, then maybe idle a burst
    task automatic offer_item(input op_t op, input logic [SAMP_W-1:0] left,
                              input logic [SAMP_W-1:0] right);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {right, left};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop offering items and wait until every predicted result has come out;
    // results still in the two pipeline stages, read stage and output register, count as due
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new rate setting, only ever with the block idle
    task automatic set_rate(input int addend, input int threshold);
        wait_drained();
        reg_write({REG_ADDEND, 2'b00}, 32'(addend));
        reg_write({REG_THRESHOLD, 2'b00}, 32'(threshold));
    endtask

    task automatic stream_traffic(input int count, input int push_w, input int frame_w,
                                  input int pop_w);
        repeat (count)
            offer_item(pick_op(push_w, frame_w, pop_w), rand_sample(), rand_sample());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset rate 785 / 1024 and empty fifo
        offer_item(OP_POP, 16'h1234, 16'h5678);        // underrun on empty
        offer_item(OP_NOP, 16'hffff, 16'hffff);        // unused code, data ignored
        offer_item(OP_PUSH, 16'h8000, 16'h7fff);
        offer_item(OP_PUSH, 16'h7fff, 16'h8000);
        offer_item(OP_PUSH, 16'h0000, 16'h0000);
        offer_item(OP_PUSH, 16'hffff, 16'hffff);
        offer_item(OP_FRAME_END, 16'hffff, 16'h0000);  // accumulator below threshold
        offer_item(OP_FRAME_END, 16'h0000, 16'hffff);  // crosses, silence padded
        offer_item(OP_NOP, 16'h0000, 16'h0000);
        repeat (5)
            offer_item(OP_POP, 16'h0000, 16'h0000);
        offer_item(OP_POP, 16'hffff, 16'hffff);        // empty again
        offer_item(OP_FRAME_END, 16'h0000, 16'h0000);
        offer_item(OP_POP, 16'h0000, 16'h0000);
        offer_item(OP_PUSH, rand_sample(), rand_sample());
        offer_item(OP_POP, 16'h0000, 16'h0000);

        // zero threshold: silence due on every frame end
        set_rate(0, 0);
        offer_item(OP_FRAME_END, 16'h0000, 16'h0000);
        offer_item(OP_FRAME_END, 16'h0000, 16'h0000);
        offer_item(OP_POP, 16'h0000, 16'h0000);
        offer_item(OP_POP, 16'h0000, 16'h0000);

        // largest addend over smallest nonzero threshold drives the accumulator to saturation
        set_rate(4095, 1);
        repeat (3)
            offer_item(OP_FRAME_END, 16'h0000, 16'h0000);
        repeat (3)
            offer_item(OP_POP, 16'h0000, 16'h0000);

        // random traffic over a range of rate settings, extremes included
        set_rate(785, 1024);
        stream_traffic(100, 40, 20, 35);
        set_rate(0, 1);
        stream_traffic(100, 40, 20, 35);
        set_rate(4095, 1);
        stream_traffic(100, 40, 20, 35);
        set_rate(4095, 4096);
        stream_traffic(100, 40, 20, 35);
        set_rate(1, 0);
        stream_traffic(100, 40, 20, 35);
        set_rate(2048, 8191);
        stream_traffic(100, 40, 20, 35);
        set_rate($urandom_range(0, 4095), $urandom_range(1, 4096));
        stream_traffic(100, 40, 20, 35);

        // push-heavy burst with silence due on every frame end
        set_rate(4095, 1);
        stream_traffic(80, 88, 10, 0);

        // pop-heavy drain
        stream_traffic(60, 2, 2, 95);

        // closing stretch without idling on either side
        calm <= 1'b1;
        set_rate($urandom_range(0, 4095), $urandom_range(1, 4096));
        stream_traffic(40, 40, 20, 35);

        wait_drained();
        if (mismatch_total == 0 && replies_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
